### rtl/fps_pkg.sv
// Package: phase, action and timer codes of the flight phase sequencer.
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  typedef enum logic [3:0] {
    PH_PRELAUNCH = 4'd0,
    PH_FILL      = 4'd1,
    PH_ARM       = 4'd2,
    PH_IGNITION  = 4'd3,
    PH_LAUNCH    = 4'd4,
    PH_BURN      = 4'd5,
    PH_COAST     = 4'd6,
    PH_BRAKING   = 4'd7,
    PH_DESCENT   = 4'd8,
    PH_TOUCHDOWN = 4'd9,
    PH_ABORT     = 4'd10,
    PH_TEST      = 4'd11
  } phase_t;

  typedef enum logic [4:0] {
    ACT_ABORT       = 5'd0,
    ACT_VENT_OPEN   = 5'd1,
    ACT_VENT_CLOSE  = 5'd2,
    ACT_FILL        = 5'd3,
    ACT_TEST        = 5'd4,
    ACT_CONFIRM1    = 5'd5,
    ACT_CONFIRM2    = 5'd6,
    ACT_ARM         = 5'd7,
    ACT_PRELAUNCH   = 5'd8,
    ACT_IGNITION    = 5'd9,
    ACT_IGN_LAUNCH  = 5'd10,
    ACT_LAUNCH_BURN = 5'd11,
    ACT_BURN_COAST  = 5'd12,
    ACT_COAST_BRAKE = 5'd13,
    ACT_COAST_DESC  = 5'd14,
    ACT_BRAKE_DESC  = 5'd15,
    ACT_DESC_TOUCH  = 5'd16
  } action_t;

  typedef enum logic [2:0] {
    TMR_NONE      = 3'd0,
    TMR_BURN      = 3'd1,
    TMR_COAST     = 3'd2,
    TMR_BRAKING   = 3'd3,
    TMR_DESCENT   = 3'd4,
    TMR_TOUCHDOWN = 3'd5
  } timer_t;

  localparam logic KIND_CONTROL = 1'b0;
  localparam logic KIND_OTHER   = 1'b1;
  localparam logic [1:0] CONFIRM_BOTH = 2'b11;
  localparam logic [1:0] CONFIRM_NONE = 2'b00;

endpackage

`default_nettype wire

### rtl/fps_if.sv
// Interfaces: command item channel and result item channel.
`timescale 1ns / 1ps
`default_nettype none

interface fps_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [4:0] action;

  modport source (output valid, output kind, output action, input ready);
  modport sink   (input valid, input kind, input action, output ready);
endinterface

interface fps_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] phase;
  logic       vent_open;
  logic       phase_changed;
  logic [2:0] timer_started;

  modport source (output valid, output phase, output vent_open, output phase_changed,
                  output timer_started, input ready);
  modport sink   (input valid, input phase, input vent_open, input phase_changed,
                  input timer_started, output ready);
endinterface

`default_nettype wire

### rtl/flight_phase_sequencer_core.sv
// Flight phase sequencer: twelve-phase state machine with vent and arm-confirm control.
`timescale 1ns / 1ps
`default_nettype none

// One command item enters per cycle unless stalled. It is registered on entry;
// once the result stage can advance, the phase logic applies it to the current
// phase, vent and confirm flags and loads one result item into the output
// register, so each item passes the command and result registers and the
// throughput is one item per cycle while results are taken. Only control
// commands (kind 0) act; any other kind still yields a result showing the
// unchanged state. The result register and the state update advance together,
// so a stalled result stalls the command stage and in_ch.ready drops only when
// both stages are full and the result is not taken. Reset puts the block in
// prelaunch with the vent closed and both arm confirms cleared.
module flight_phase_sequencer_core
  import fps_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  fps_in_if.sink      in_ch,
  fps_out_if.source   out_ch
);

  // command stage
  logic       cmd_v_r;
  logic       cmd_kind_r;
  logic [4:0] cmd_action_r;

  // architectural state
  phase_t     phase_r;
  logic       vent_r;
  logic [1:0] conf_r;

  // result stage
  logic       out_v_r;
  logic [3:0] out_phase_r;
  logic       out_vent_r;
  logic       out_changed_r;
  logic [2:0] out_timer_r;

  logic out_adv;
  logic cmd_adv;
  logic in_take;

  assign out_adv = !out_v_r || out_ch.ready;
  assign cmd_adv = cmd_v_r && out_adv;
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !cmd_v_r || out_adv;

  // next-state logic
  phase_t     phase_nxt;
  phase_t     cand;
  logic       vent_nxt;
  logic [1:0] conf_nxt;
  logic       changed;
  timer_t     timer;
  logic       gen_ok;

  always_comb begin
    cand     = phase_r;
    vent_nxt = vent_r;
    conf_nxt = conf_r;
    gen_ok   = 1'b0;
    changed  = 1'b0;
    timer    = TMR_NONE;

    if (cmd_kind_r == KIND_CONTROL) begin
      unique case (phase_r)
        PH_PRELAUNCH: begin
          if (cmd_action_r == ACT_FILL) cand = PH_FILL;
          else if (cmd_action_r == ACT_TEST) cand = PH_TEST;
          else gen_ok = 1'b1;
        end
        PH_FILL: begin
          if (cmd_action_r == ACT_CONFIRM1) conf_nxt[0] = 1'b1;
          else if (cmd_action_r == ACT_CONFIRM2) conf_nxt[1] = 1'b1;
          else if (cmd_action_r == ACT_ARM) begin
            if (conf_r == CONFIRM_BOTH) cand = PH_ARM;
          end
          else if (cmd_action_r == ACT_PRELAUNCH) cand = PH_PRELAUNCH;
          else gen_ok = 1'b1;
        end
        PH_ARM: begin
          if (cmd_action_r == ACT_IGNITION) cand = PH_IGNITION;
          else if (cmd_action_r == ACT_FILL) cand = PH_FILL;
          else gen_ok = 1'b1;
        end
        PH_IGNITION: begin
          if (cmd_action_r == ACT_IGN_LAUNCH) cand = PH_LAUNCH;
          else if (cmd_action_r == ACT_ARM) cand = PH_ARM;
          else if (cmd_action_r == ACT_PRELAUNCH) cand = PH_PRELAUNCH;
        end
        PH_LAUNCH: begin
          if (cmd_action_r == ACT_LAUNCH_BURN) cand = PH_BURN;
          else if (cmd_action_r == ACT_PRELAUNCH) cand = PH_PRELAUNCH;
        end
        PH_BURN: begin
          if (cmd_action_r == ACT_BURN_COAST) cand = PH_COAST;
          else if (cmd_action_r == ACT_PRELAUNCH) cand = PH_PRELAUNCH;
        end
        PH_COAST: begin
          if (cmd_action_r == ACT_COAST_BRAKE) cand = PH_BRAKING;
          else if (cmd_action_r == ACT_COAST_DESC) cand = PH_DESCENT;
          else if (cmd_action_r == ACT_PRELAUNCH) cand = PH_PRELAUNCH;
        end
        PH_BRAKING: begin
          if (cmd_action_r == ACT_BRAKE_DESC) cand = PH_DESCENT;
          else if (cmd_action_r == ACT_PRELAUNCH) cand = PH_PRELAUNCH;
        end
        PH_DESCENT: begin
          if (cmd_action_r == ACT_DESC_TOUCH) cand = PH_TOUCHDOWN;
          else if (cmd_action_r == ACT_PRELAUNCH) cand = PH_PRELAUNCH;
        end
        PH_TOUCHDOWN: gen_ok = 1'b1;
        PH_ABORT: begin
          if (cmd_action_r == ACT_PRELAUNCH) cand = PH_PRELAUNCH;
          else if (cmd_action_r == ACT_TEST) cand = PH_TEST;
        end
        PH_TEST: begin
          if (cmd_action_r == ACT_PRELAUNCH) cand = PH_PRELAUNCH;
          else gen_ok = 1'b1;
        end
        default: cand = phase_r;  // unreachable codes hold
      endcase

      // general actions: abort, vent open, vent close
      if (gen_ok) begin
        if (cmd_action_r == ACT_ABORT) cand = PH_ABORT;
        else if (cmd_action_r == ACT_VENT_OPEN) vent_nxt = 1'b1;
        else if (cmd_action_r == ACT_VENT_CLOSE) vent_nxt = 1'b0;
      end
    end

    phase_nxt = cand;
    if (cand != phase_r) begin
      changed = 1'b1;
      if (phase_r == PH_FILL) conf_nxt = CONFIRM_NONE;  // exit action of fill
      // entry actions
      unique case (cand)
        PH_FILL: begin
          vent_nxt = 1'b0;
          conf_nxt = CONFIRM_NONE;
        end
        PH_LAUNCH: begin
          vent_nxt = 1'b0;
          timer    = TMR_BURN;
        end
        PH_BURN: begin
          vent_nxt = 1'b0;
          timer    = TMR_COAST;
        end
        PH_COAST: begin
          vent_nxt = 1'b0;
          timer    = TMR_BRAKING;
        end
        PH_BRAKING: begin
          vent_nxt = 1'b0;
          timer    = TMR_DESCENT;
        end
        PH_DESCENT: begin
          vent_nxt = 1'b1;
          timer    = TMR_TOUCHDOWN;
        end
        PH_TOUCHDOWN, PH_ABORT: vent_nxt = 1'b1;
        PH_TEST: vent_nxt = vent_nxt;  // vent left as it is
        default: vent_nxt = 1'b0;      // prelaunch, arm, ignition
      endcase
    end
  end

  // command stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      cmd_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_kind_r   <= in_ch.kind;
      cmd_action_r <= in_ch.action;
    end
  end

  // state and result registers advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRELAUNCH;
      vent_r  <= 1'b0;
      conf_r  <= CONFIRM_NONE;
      out_v_r <= 1'b0;
    end else begin
      if (out_adv) out_v_r <= cmd_v_r;
      if (cmd_adv) begin
        phase_r <= phase_nxt;
        vent_r  <= vent_nxt;
        conf_r  <= conf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_adv) begin
      out_phase_r   <= phase_nxt;
      out_vent_r    <= vent_nxt;
      out_changed_r <= changed;
      out_timer_r   <= timer;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.phase         = out_phase_r;
  assign out_ch.vent_open     = out_vent_r;
  assign out_ch.phase_changed = out_changed_r;
  assign out_ch.timer_started = out_timer_r;

  // confirms can only be held while in fill
  a_conf_only_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (conf_r != CONFIRM_NONE) |-> (phase_r == PH_FILL))
    else $error("arm confirms set outside fill");

  // a pending result always reflects the live state
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_phase_r == phase_r && out_vent_r == vent_r))
    else $error("pending result differs from state");

  // a timer starts only on a phase change
  a_timer_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_timer_r != TMR_NONE) |-> out_changed_r)
    else $error("timer reported without phase change");

endmodule

`default_nettype wire
